// ===== sv/rbd_pkg.sv =====
// rbd_pkg: shared constants, register indexes and payload types for the
// rgb 2x2 box downscaler. No dependencies.
`timescale 1ns / 1ps

package rbd_pkg;

  // largest input width the line buffer is sized for
  localparam int MAX_WIDTH    = 2048;
  localparam int HEIGHT_LIMIT = 2048;

  localparam int CFG_W     = 12;  // width of each configuration register
  localparam int CFG_IDX_W = 2;   // register index port width
  localparam int CHAN_W    = 8;
  localparam int SUM_W     = CHAN_W + 1;  // sum of two samples

  localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam int ROW_W      = $clog2(HEIGHT_LIMIT);
  localparam int ADDR_W     = COL_W - 1;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;

  // compare widths wide enough for counter + 2 and the register values
  localparam int WCMP_W = (COL_W + 2 > CFG_W + 1) ? COL_W + 2 : CFG_W + 1;
  localparam int HCMP_W = (ROW_W + 2 > CFG_W + 1) ? ROW_W + 2 : CFG_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] IN_WIDTH_RST  = CFG_W'(2048);
  localparam logic [CFG_W-1:0] IN_HEIGHT_RST = CFG_W'(2048);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  // one line buffer entry: per-channel sums of a horizontal pair
  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } pair_sum_t;

  localparam int PAIR_SUM_W = $bits(pair_sum_t);

endpackage

// ===== sv/rbd_if.sv =====
// rbd_pix_in_if / rbd_pix_out_if: valid/ready channels for input pixels and
// downscaled output words. Depends on rbd_pkg.
`timescale 1ns / 1ps

interface rbd_pix_in_if
  import rbd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rbd_pix_out_if
  import rbd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic              row_end;
  logic              frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output row_end, output frame_end, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input row_end, input frame_end, output ready);
endinterface

// ===== sv/rbd_line_ram.sv =====
// rbd_line_ram: simple dual-port synchronous ram, one write and one read port,
// read data registered and held between reads. No dependencies.
`timescale 1ns / 1ps

module rbd_line_ram #(
  parameter int WIDTH  = 27,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rgb_box_downscale_2x2.sv =====
// rgb_box_downscale_2x2: top level of the 2x2 box-filter downscaler.
// Depends on rbd_pkg, rbd_pix_in_if / rbd_pix_out_if and rbd_line_ram.
`timescale 1ns / 1ps

// usage
//   pix_i takes rgb pixels in raster order, one word per cycle when ready is
//   high. pix_o gives one averaged word per 2x2 block, with row_end on the
//   last word of an output row and frame_end on the last word of the frame.
//   in_width / in_height are written through the cfg port while idle; values
//   outside [2, max width] / [2, 2048] are saturated.
// throughput
//   one pixel per cycle, sustained unless the stall below drops pix_i.ready. the
//   line ram takes one access per pixel pair (write on even rows, read on odd
//   rows), so one port of each kind carries the full rate.
// pipeline
//   the line ram read and the pair sum register at the edge that accepts the
//   pixel closing a block; the final add then lands in the output register
//   once that register is free, and the word is held there until the sink
//   takes it.
// reset
//   counters restart at the top left corner, the held pixel clears, both
//   registers return to 2048. the line ram holds no reset value and needs no
//   clearing pass: every read follows a write made by the previous row.
// stall
//   a word waiting in the output register does not block input; only when
//   both the final-add stage and the output register are full and the sink
//   holds ready low does pix_i.ready drop.

module rgb_box_downscale_2x2
  import rbd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  rbd_pix_in_if.sink           pix_i,
  rbd_pix_out_if.source        pix_o
);

  // configuration registers
  logic [CFG_W-1:0] in_width_q, in_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q  <= IN_WIDTH_RST;
      in_height_q <= IN_HEIGHT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_IN_WIDTH) begin
        in_width_q <= cfg_data_i;
      end else if (cfg_idx_i == REG_IN_HEIGHT) begin
        in_height_q <= cfg_data_i;
      end
    end
  end

  // saturated geometry
  logic [WCMP_W-1:0] width_raw, width_eff;
  logic [HCMP_W-1:0] height_raw, height_eff;

  assign width_raw  = WCMP_W'(in_width_q);
  assign height_raw = HCMP_W'(in_height_q);

  always_comb begin
    priority if (width_raw < WCMP_W'(2)) begin
      width_eff = WCMP_W'(2);
    end else if (width_raw > WCMP_W'(MAX_WIDTH)) begin
      width_eff = WCMP_W'(MAX_WIDTH);
    end else begin
      width_eff = width_raw;
    end
    priority if (height_raw < HCMP_W'(2)) begin
      height_eff = HCMP_W'(2);
    end else if (height_raw > HCMP_W'(HEIGHT_LIMIT)) begin
      height_eff = HCMP_W'(HEIGHT_LIMIT);
    end else begin
      height_eff = height_raw;
    end
  end

  // pipeline control
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, s1_move, accept;

  assign out_free = !out_valid_q || pix_o.ready;
  assign s1_move  = s1_valid_q && out_free;
  // the final-add stage always drains into the output register when it can
  assign pix_i.ready = !s1_valid_q || out_free;
  assign accept      = pix_i.valid && pix_i.ready;

  // position counters and the even-column pixel
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  pix_t             held_q;
  logic             odd_col, odd_row;
  logic             col_wrap, row_wrap, row_end, frame_end;

  assign odd_col = col_q[0];
  assign odd_row = row_q[0];

  assign col_wrap  = (WCMP_W'(col_q) + WCMP_W'(1)) >= width_eff;
  assign row_wrap  = (HCMP_W'(row_q) + HCMP_W'(1)) >= height_eff;
  assign row_end   = (WCMP_W'(col_q) + WCMP_W'(2)) >= width_eff;
  assign frame_end = row_end && ((HCMP_W'(row_q) + HCMP_W'(2)) >= height_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept && !odd_col) begin
        held_q <= '{red: pix_i.red, green: pix_i.green, blue: pix_i.blue};
      end
    end
  end

  // horizontal pair sums of the pixel on the port and the held pixel
  pair_sum_t pair_sum;

  assign pair_sum.red   = SUM_W'(held_q.red)   + SUM_W'(pix_i.red);
  assign pair_sum.green = SUM_W'(held_q.green) + SUM_W'(pix_i.green);
  assign pair_sum.blue  = SUM_W'(held_q.blue)  + SUM_W'(pix_i.blue);

  // line buffer: even rows write, odd rows read; the two never share a cycle,
  // and a read always comes at least two pixels after the write of its entry
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  pair_sum_t         ram_rdata;

  assign ram_we   = accept && odd_col && !odd_row;
  assign ram_re   = accept && odd_col && odd_row;
  assign ram_addr = col_q[COL_W-1:1];

  rbd_line_ram #(
    .WIDTH  (PAIR_SUM_W),
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (pair_sum),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // stage 1: pair sum of the odd row waits for the ram read data
  pair_sum_t s1_sum_q;
  logic      s1_row_end_q, s1_frame_end_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (ram_re) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      s1_sum_q       <= pair_sum;
      s1_row_end_q   <= row_end;
      s1_frame_end_q <= frame_end;
    end
  end

  // four-sample sums, divide by four by dropping the low bits
  logic [SUM_W:0] tot_red, tot_green, tot_blue;

  assign tot_red   = (SUM_W + 1)'(s1_sum_q.red)   + (SUM_W + 1)'(ram_rdata.red);
  assign tot_green = (SUM_W + 1)'(s1_sum_q.green) + (SUM_W + 1)'(ram_rdata.green);
  assign tot_blue  = (SUM_W + 1)'(s1_sum_q.blue)  + (SUM_W + 1)'(ram_rdata.blue);

  // output register
  pix_t out_pix_q;
  logic out_row_end_q, out_frame_end_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_pix_q.red   <= tot_red[SUM_W:2];
      out_pix_q.green <= tot_green[SUM_W:2];
      out_pix_q.blue  <= tot_blue[SUM_W:2];
      out_row_end_q   <= s1_row_end_q;
      out_frame_end_q <= s1_frame_end_q;
    end
  end

  assign pix_o.valid     = out_valid_q;
  assign pix_o.out_red   = out_pix_q.red;
  assign pix_o.out_green = out_pix_q.green;
  assign pix_o.out_blue  = out_pix_q.blue;
  assign pix_o.row_end   = out_row_end_q;
  assign pix_o.frame_end = out_frame_end_q;

  // checks
  a_ram_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("line ram written and read in one cycle");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !pix_o.ready) |-> !pix_i.ready)
    else $error("input taken while both stages are blocked");

  a_s1_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> out_valid_q)
    else $error("stage 1 word lost");

  a_frame_has_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_frame_end_q) |-> out_row_end_q)
    else $error("frame end without row end");

  a_read_on_odd_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (odd_row && odd_col && pix_i.ready))
    else $error("line ram read outside an odd row pair");

endmodule
